// File: hw/rtl/weighted_histogram_normalizer_unit_defines.svh
// Assertion macros shared by the histogram normaliser RTL.
`ifndef WEIGHTED_HISTOGRAM_NORMALIZER_UNIT_DEFINES_SVH
`define WEIGHTED_HISTOGRAM_NORMALIZER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on the rising clock edge, skipped while reset is low.
`define WHN_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("whn assertion failed");
// Check a property on every rising clock edge, reset included.
`define WHN_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("whn assertion failed");
`else
`define WHN_ASSERT(lbl, clk, rst_n, prop)
`define WHN_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: hw/rtl/whn_pkg.sv
// Shared types and constants of the weighted histogram normaliser.
`timescale 1ns / 1ps
package whn_pkg;
    localparam int MAX_BINS  = 64;
    localparam int IDX_W     = 6;
    localparam int BIN_W     = 48;
    localparam int TOT_W     = 54;
    localparam int FRAC_W    = 17;
    localparam int CNT_W     = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT = 2'd2;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic mul;
        logic div_init_add;
        logic div_init_frac;
        logic div_step;
        logic bin_rd;
        logic bin_wr;
        logic sum_rd;
        logic frac_rd;
        logic idx_clr;
        logic idx_inc;
        logic out_load_bin;
        logic out_load_empty;
        logic clr_bins;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_finish;
        logic keep;
        logic step_done;
        logic idx_last;
        logic total_zero;
        logic out_free;
    } t_sts;
endpackage

// File: hw/rtl/whn_ctrl.sv
// Controller state machine of the histogram normaliser.
`timescale 1ns / 1ps
module whn_ctrl import whn_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_CHK, S_ADIV, S_RD, S_WR,
        S_SUM, S_SUMEND, S_TOT, S_EMPTY, S_FRD, S_FLD, S_FDIV, S_EMIT
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // Decode commands and next state
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (i_sts.is_finish) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state = S_SUM;
                end else begin
                    o_cmd.mul = 1'b1;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.keep) begin
                    o_cmd.div_init_add = 1'b1;
                    n_state = S_ADIV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ADIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.step_done) n_state = S_RD;
            end
            S_RD: begin
                o_cmd.bin_rd = 1'b1;
                n_state = S_WR;
            end
            S_WR: begin
                o_cmd.bin_wr = 1'b1;
                n_state = S_IDLE;
            end
            S_SUM: begin
                o_cmd.sum_rd  = 1'b1;
                o_cmd.idx_inc = 1'b1;
                if (i_sts.idx_last) n_state = S_SUMEND;
            end
            S_SUMEND: n_state = S_TOT;
            S_TOT: begin
                o_cmd.idx_clr = 1'b1;
                n_state = i_sts.total_zero ? S_EMPTY : S_FRD;
            end
            S_EMPTY: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load_empty = 1'b1;
                    o_cmd.clr_bins       = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_FRD: begin
                o_cmd.frac_rd = 1'b1;
                n_state = S_FLD;
            end
            S_FLD: begin
                o_cmd.div_init_frac = 1'b1;
                n_state = S_FDIV;
            end
            S_FDIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.step_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load_bin = 1'b1;
                    if (i_sts.idx_last) begin
                        o_cmd.clr_bins = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state = S_FRD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// File: hw/rtl/whn_dp.sv
// Datapath of the histogram normaliser: registers, bin memory, divider, output word.
`timescale 1ns / 1ps
`include "weighted_histogram_normalizer_unit_defines.svh"
module whn_dp import whn_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_op,
    input  logic [31:0]          i_sample_value,
    input  logic [31:0]          i_weight,
    input  logic                 i_out_ready,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    output logic                 o_out_valid,
    output logic [IDX_W-1:0]     o_bin_index,
    output logic [FRAC_W-1:0]    o_fraction,
    output logic                 o_empty_res,
    output logic                 o_last
);
    logic signed [31:0] r_range_min, r_range_max;
    logic [CNT_W-1:0]   r_bin_count;
    logic [CNT_W-1:0]   w_n;
    logic [IDX_W-1:0]   w_n_m1;

    logic               r_op;
    logic [31:0]        r_weight;
    logic signed [32:0] r_diff;
    logic [32:0]        r_span;
    logic               r_rng_ok;
    logic [39:0]        r_prod;
    logic [32:0]        w_abs;

    logic [63:0]        r_rem;
    logic [TOT_W-1:0]   r_div;
    logic [FRAC_W-1:0]  r_q;
    logic [4:0]         r_step;
    logic [69:0]        w_trial;

    logic [BIN_W-1:0]   r_mem [MAX_BINS];
    logic [MAX_BINS-1:0] r_vld;
    logic [BIN_W-1:0]   r_rdata;
    logic               r_rvld;
    logic [BIN_W-1:0]   w_bw;
    logic [IDX_W-1:0]   w_raddr;
    logic [BIN_W:0]     w_sum;

    logic [IDX_W-1:0]   r_idx;
    logic               r_sum_pend;
    logic [TOT_W-1:0]   r_total;

    logic               r_out_valid;
    logic [IDX_W-1:0]   r_out_idx;
    logic [FRAC_W-1:0]  r_out_frac;
    logic               r_out_empty, r_out_last;

    // Clamp the bin count to 1..MAX_BINS
    always_comb begin
        if (r_bin_count == '0) w_n = CNT_W'(1);
        else if (r_bin_count > CNT_W'(MAX_BINS)) w_n = CNT_W'(MAX_BINS);
        else w_n = r_bin_count;
    end
    assign w_n_m1 = IDX_W'(w_n - CNT_W'(1));

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_min <= 32'sd0;
            r_range_max <= 32'sd65536;
            r_bin_count <= CNT_W'(MAX_BINS);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RANGE_MIN: r_range_min <= i_cfg_data;
                CFG_RANGE_MAX: r_range_max <= i_cfg_data;
                CFG_BIN_COUNT: r_bin_count <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_abs = r_diff[32] ? 33'(-r_diff) : 33'(r_diff);

    // Latch the input word and scale the offset by the bin count
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op     <= i_op;
            r_weight <= i_weight;
            r_diff   <= 33'(signed'(i_sample_value)) - 33'(r_range_min);
            r_span   <= 33'(r_range_max) - 33'(r_range_min);
            r_rng_ok <= (r_range_max > r_range_min);
        end
        if (i_cmd.mul) begin
            r_prod <= 40'(w_abs) * 40'(w_n);
        end
    end

    // Shared restoring divider, one quotient bit a cycle
    assign w_trial = {16'd0, r_div} << r_step;
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init_add) begin
            r_rem  <= {24'd0, r_prod};
            r_div  <= {21'd0, r_span};
            r_q    <= '0;
            r_step <= 5'd5;
        end else if (i_cmd.div_init_frac) begin
            r_rem  <= {w_bw, 16'd0};
            r_div  <= r_total;
            r_q    <= '0;
            r_step <= 5'd16;
        end else if (i_cmd.div_step) begin
            if ({6'd0, r_rem} >= w_trial) begin
                r_rem        <= r_rem - w_trial[63:0];
                r_q[r_step]  <= 1'b1;
            end
            if (r_step != '0) r_step <= r_step - 5'd1;
        end
    end

    // Bin memory, read registered; entries not marked valid read as zero
    assign w_raddr = i_cmd.bin_rd ? r_q[IDX_W-1:0] : r_idx;
    assign w_bw    = r_rvld ? r_rdata : '0;
    assign w_sum   = {1'b0, w_bw} + {17'd0, r_weight};
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[w_raddr];
        r_rvld  <= r_vld[w_raddr];
        if (i_cmd.bin_wr) begin
            r_mem[r_q[IDX_W-1:0]] <= w_sum[BIN_W] ? {BIN_W{1'b1}} : w_sum[BIN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_bins) begin
            r_vld <= '0;
        end else if (i_cmd.bin_wr) begin
            r_vld[r_q[IDX_W-1:0]] <= 1'b1;
        end
    end

    // Bin counter and total accumulation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_pend <= 1'b0;
        end else begin
            r_sum_pend <= i_cmd.sum_rd;
        end
        if (i_cmd.idx_clr) r_idx <= '0;
        else if (i_cmd.idx_inc) r_idx <= r_idx + IDX_W'(1);
        if (i_cmd.load_in) r_total <= '0;
        else if (r_sum_pend) r_total <= r_total + TOT_W'(w_bw);
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load_bin || i_cmd.out_load_empty) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load_bin) begin
            r_out_idx   <= r_idx;
            r_out_frac  <= r_q;
            r_out_empty <= 1'b0;
            r_out_last  <= (r_idx == w_n_m1);
        end else if (i_cmd.out_load_empty) begin
            r_out_idx   <= '0;
            r_out_frac  <= '0;
            r_out_empty <= 1'b1;
            r_out_last  <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_bin_index = r_out_idx;
    assign o_fraction  = r_out_frac;
    assign o_empty_res = r_out_empty;
    assign o_last      = r_out_last;

    // Status to the controller
    always_comb begin
        o_sts.is_finish  = (r_op == OP_FINISH);
        o_sts.keep       = r_rng_ok &&
                           (r_diff[32] ? (r_prod < {7'd0, r_span})
                                       : (33'(r_diff) < r_span));
        o_sts.step_done  = (r_step == '0);
        o_sts.idx_last   = (r_idx == w_n_m1);
        o_sts.total_zero = (r_total == '0);
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    `WHN_ASSERT(a_load_when_free, i_clk, i_rst_n, (i_cmd.out_load_bin || i_cmd.out_load_empty) |-> (!r_out_valid || i_out_ready))
    `WHN_ASSERT(a_bin_in_range, i_clk, i_rst_n, i_cmd.bin_wr |-> ({1'b0, r_q[IDX_W-1:0]} < w_n))
    `WHN_ASSERT(a_frac_nonzero_total, i_clk, i_rst_n, i_cmd.div_init_frac |-> (r_total != '0))
    `WHN_ASSERT(a_frac_bound, i_clk, i_rst_n, i_cmd.out_load_bin |-> (r_q <= FRAC_W'(65536)))
endmodule

// File: hw/rtl/weighted_histogram_normalizer_unit.sv
// Top level of the weighted histogram normaliser.
// Usage:
//   Input stream s_*: tuser = op (0 add sample, 1 finish), tdata = sample_value
//   in bits 31:0 and weight in bits 63:32. Output stream m_*: tdata = bin_index
//   then fraction then a zero pad bit, tuser = empty_res, tlast = last of a run.
//   Configuration (range_min, range_max, bin_count) by i_cfg_we/i_cfg_idx/
//   i_cfg_data; the user must write it only while the block is idle (not enforced).
// Sequence:
//   An add word is dropped after multiply and range check, or else goes through
//   multiply, range check, six divider steps, bin read and write; the shared
//   divider yields one quotient bit a cycle. A finish word sums the n bins,
//   then per bin reads it, loads the divider, runs 17 divider steps and emits.
//   s_tready is high only while no word is in progress.
// Reset clears the configuration to 0 / 65536 / 64 and all bins at once by
//   clearing their valid bits; bins are cleared the same way after a finish.
// A stalled receiver holds the output word; the finish run waits for it and
//   the next input word is taken while the last result still waits.
`timescale 1ns / 1ps
module weighted_histogram_normalizer_unit import whn_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [63:0]          s_tdata,   // sample_value[31:0], weight[63:32]
    input  logic                 s_tuser,   // op
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,   // bin_index[5:0], fraction[22:6], zero[23]
    output logic                 m_tuser,   // empty_res
    output logic                 m_tlast
);
    t_cmd               w_cmd;
    t_sts               w_sts;
    logic [IDX_W-1:0]   w_bin_index;
    logic [FRAC_W-1:0]  w_fraction;

    whn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .o_in_ready (s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    whn_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_op           (s_tuser),
        .i_sample_value (s_tdata[31:0]),
        .i_weight       (s_tdata[63:32]),
        .i_out_ready    (m_tready),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_out_valid    (m_tvalid),
        .o_bin_index    (w_bin_index),
        .o_fraction     (w_fraction),
        .o_empty_res    (m_tuser),
        .o_last         (m_tlast)
    );

    assign m_tdata = {1'b0, w_fraction, w_bin_index};
endmodule

// File: test/tb_top.sv
// Self-checking testbench of the weighted histogram normaliser.
`timescale 1ns / 1ps
module tb_top;
    import whn_pkg::*;

    typedef struct {
        logic        op;
        logic [31:0] sample;
        logic [31:0] weight;
    } t_item;

    typedef struct {
        logic [5:0]  idx;
        logic [16:0] frac;
        logic        empty;
        logic        last;
    } t_bin_res;

    // one directed row; chk marks a typed-in expectation for single-result finishes
    typedef struct {
        logic        op;
        logic [31:0] sample;
        logic [31:0] weight;
        logic        chk;
        t_bin_res    res;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [31:0]          i_cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [63:0]          s_tdata;   // sample_value[31:0], weight[63:32]
    logic                 s_tuser;   // op
    logic                 m_tvalid;
    logic                 m_tready;
    logic [23:0]          m_tdata;   // bin_index[5:0], fraction[22:6], zero[23]
    logic                 m_tuser;   // empty_res
    logic                 m_tlast;

    weighted_histogram_normalizer_unit i_dut (.*);

    // predictor state
    logic signed [31:0] lo_edge;
    logic signed [31:0] hi_edge;
    logic [6:0]         nbins_cfg;
    logic [47:0]        bin_acc [MAX_BINS];

    t_bin_res exp_bins [$];
    int       fail_cnt;
    int       res_cnt;
    int       word_cnt;
    bit       stall_on;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic int bins_active();
        int n;
        n = nbins_cfg;
        if (n == 0) n = 1;
        if (n > MAX_BINS) n = MAX_BINS;
        return n;
    endfunction

    // classify, accumulate, or emit normalised shares
    task automatic predict_word(input t_item it);
        int           n;
        longint       span;
        longint       bidx;
        logic [53:0]  total;
        logic [48:0]  sum;
        logic [69:0]  num;
        t_bin_res     r;
        n = bins_active();
        if (it.op == OP_ADD) begin
            if (hi_edge <= lo_edge) return;
            span = longint'(hi_edge) - longint'(lo_edge);
            bidx = ((longint'($signed(it.sample)) - longint'(lo_edge)) * n) / span;
            if (bidx < 0 || bidx >= n) return;
            sum = {1'b0, bin_acc[bidx]} + {17'd0, it.weight};
            bin_acc[bidx] = sum[48] ? 48'hFFFF_FFFF_FFFF : sum[47:0];
        end else begin
            total = '0;
            for (int i = 0; i < n; i++) total += bin_acc[i];
            if (total == 0) begin
                r = '{idx: 6'd0, frac: 17'd0, empty: 1'b1, last: 1'b1};
                exp_bins.push_back(r);
            end else begin
                for (int i = 0; i < n; i++) begin
                    num = {bin_acc[i], 16'd0};
                    r.idx = i[5:0];
                    r.frac = 17'(num / total);
                    r.empty = 1'b0;
                    r.last = (i == n - 1);
                    exp_bins.push_back(r);
                end
            end
            for (int i = 0; i < MAX_BINS; i++) bin_acc[i] = '0;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_RANGE_MIN: lo_edge = val;
            CFG_RANGE_MAX: hi_edge = val;
            CFG_BIN_COUNT: nbins_cfg = val[6:0];
            default: ;
        endcase
    endtask

    // drop valid, wait until every expected word has come, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (exp_bins.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic configure(input logic [31:0] mn, input logic [31:0] mx,
                             input logic [6:0] nb);
        drain();
        write_reg(CFG_RANGE_MIN, mn);
        write_reg(CFG_RANGE_MAX, mx);
        write_reg(CFG_BIN_COUNT, {25'd0, nb});
    endtask

    // present one word at the falling edge, hold until taken
    task automatic send_word(input t_item it);
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= {it.weight, it.sample};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        predict_word(it);
        word_cnt++;
        @(negedge i_clk);
    endtask

    task automatic idle_gap(input int cyc);
        s_tvalid <= 1'b0;
        repeat (cyc) @(negedge i_clk);
    endtask

    // mostly in-range samples with random content, some noise
    function automatic t_item rand_item(input int fin_pct);
        t_item it;
        longint span;
        it.op = ($urandom_range(99) < fin_pct) ? OP_FINISH : OP_ADD;
        span = longint'(hi_edge) - longint'(lo_edge);
        if ($urandom_range(9) < 7 && span > 0)
            it.sample = 32'(longint'(lo_edge) + ($urandom() % span));
        else
            it.sample = $urandom();
        case ($urandom_range(3))
            0: it.weight = $urandom();
            1: it.weight = $urandom_range(65535);
            2: it.weight = 32'hFFFF_FFFF;
            default: it.weight = $urandom_range(1 << 20);
        endcase
        return it;
    endfunction

    // check output words against the oldest expectation
    always @(posedge i_clk) begin
        t_bin_res e;
        if (i_rst_n && m_tvalid && m_tready) begin
            res_cnt++;
            if (exp_bins.size() == 0) begin
                $display("%0t: unexpected word idx=%0d frac=%0d", $time,
                         m_tdata[5:0], m_tdata[22:6]);
                fail_cnt++;
            end else begin
                e = exp_bins.pop_front();
                if (m_tdata[5:0] !== e.idx || m_tdata[22:6] !== e.frac ||
                    m_tdata[23] !== 1'b0 || m_tuser !== e.empty ||
                    m_tlast !== e.last) begin
                    $display("%0t: mismatch exp idx=%0d frac=%0d empty=%0b last=%0b",
                             $time, e.idx, e.frac, e.empty, e.last);
                    $display("%0t:          got idx=%0d frac=%0d empty=%0b last=%0b",
                             $time, m_tdata[5:0], m_tdata[22:6], m_tuser, m_tlast);
                    fail_cnt++;
                end
            end
        end
    end

    // receiver stalls on its own pattern, with stall-free stretches
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if ($urandom_range(63) == 0) stall_on = !stall_on;
            m_tready <= stall_on ? ($urandom_range(3) != 0) : 1'b1;
        end
    end

    initial begin
        #40_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        t_row  rows [$];
        t_item it;
        t_bin_res er;
        int    burst;
        fail_cnt = 0;
        res_cnt = 0;
        word_cnt = 0;
        stall_on = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        lo_edge = 0;
        hi_edge = 65536;
        nbins_cfg = 7'd64;
        for (int i = 0; i < MAX_BINS; i++) bin_acc[i] = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed table: reset defaults, empty finish, extremes, repeated full weights
        er = '{idx: 6'd0, frac: 17'd0, empty: 1'b1, last: 1'b1};
        rows.push_back('{OP_FINISH, 32'd0, 32'd0, 1'b1, er});
        rows.push_back('{OP_ADD, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, er});
        rows.push_back('{OP_ADD, 32'h0000_FFFF, 32'd1, 1'b0, er});
        rows.push_back('{OP_ADD, 32'hFFFF_FFFF, 32'd7, 1'b0, er});   // just below min
        rows.push_back('{OP_ADD, 32'h0001_0000, 32'd5, 1'b0, er});   // at max, dropped
        rows.push_back('{OP_ADD, 32'h8000_0000, 32'd9, 1'b0, er});
        rows.push_back('{OP_ADD, 32'h7FFF_FFFF, 32'd9, 1'b0, er});
        rows.push_back('{OP_FINISH, 32'd0, 32'd0, 1'b0, er});
        rows.push_back('{OP_ADD, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, er}); // dropped
        rows.push_back('{OP_ADD, 32'h0000_8000, 32'd0, 1'b0, er});   // zero weight
        rows.push_back('{OP_FINISH, 32'd0, 32'd0, 1'b1, er});
        for (int i = 0; i < 4; i++)                                   // repeated full weights into one bin
            rows.push_back('{OP_ADD, 32'h0000_0100, 32'hFFFF_FFFF, 1'b0, er});
        for (int i = 0; i < 70000; i += 20000)
            rows.push_back('{OP_ADD, 32'h0000_0100, 32'hFFFF_FFFF, 1'b0, er});
        rows.push_back('{OP_ADD, 32'h0000_F000, 32'h0001_0000, 1'b0, er});
        rows.push_back('{OP_FINISH, 32'd0, 32'd0, 1'b0, er});
        foreach (rows[k]) begin
            it = '{rows[k].op, rows[k].sample, rows[k].weight};
            send_word(it);
            if (rows[k].chk) begin
                // typed-in expectation must agree with the predictor
                if (exp_bins.size() == 0 || exp_bins[$] != rows[k].res) begin
                    $display("%0t: directed row %0d expectation disagrees", $time, k);
                    fail_cnt++;
                end
            end
        end

        // full-scale range, one bin, then bin count changed before a finish
        configure(32'h8000_0000, 32'h7FFF_FFFF, 7'd1);
        for (int i = 0; i < 4; i++) send_word(rand_item(0));
        send_word('{OP_FINISH, 32'd0, 32'd0});
        for (int i = 0; i < 6; i++) send_word(rand_item(0));
        drain();
        write_reg(CFG_BIN_COUNT, 32'd3);
        send_word('{OP_FINISH, 32'd0, 32'd0});
        configure(32'hFFFF_0000, 32'h0002_0000, 7'd0);   // zero acts as one
        send_word('{OP_ADD, 32'hFFFF_0000, 32'd3});
        send_word('{OP_FINISH, 32'd0, 32'd0});
        configure(32'h0001_0000, 32'h0001_0000, 7'd100); // empty range, above max
        send_word('{OP_ADD, 32'h0001_0000, 32'd3});
        send_word('{OP_FINISH, 32'd0, 32'd0});

        // random phases across several settings
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: configure(32'h0000_0000, 32'h0010_0000, 7'd4);
                1: configure($urandom(), $urandom(), 7'($urandom_range(127)));
                2: configure(32'hFFF0_0000, 32'h0000_1000, 7'd64);
                3: configure(32'h8000_0000, 32'h7FFF_FFFF, 7'd2);
                default: configure(32'h0000_0000, 32'h0000_0010, 7'd8);
            endcase
            for (int k = 0; k < 24; ) begin
                burst = $urandom_range(1, 8);
                for (int b = 0; b < burst && k < 24; b++, k++)
                    send_word(rand_item(ph == 2 ? 3 : 12));
                if (k == 16) drain();
                else idle_gap($urandom_range(1, 5));
            end
            send_word('{OP_FINISH, 32'd0, 32'd0});
        end
        drain();

        $display("Covered %0d input words and %0d result words over several ranges",
                 word_cnt, res_cnt);
        $display("and bin counts, with sender gaps and receiver stalls.");
        if (fail_cnt == 0 && exp_bins.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
